FILE: design/ilid_pkg.sv
package ilid_pkg;

    localparam int ILID_CAPACITY = 16;

    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int LEN_W = 5;
    localparam int VAL_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    // One result beat as it leaves the sequencer.
    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] list_length;
        logic             has_item;
        logic [VAL_W-1:0] item_value;
        logic             last;
    } res_t;

endpackage

FILE: design/ilid_ram.sv
module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/ilid_ctrl.sv
module ilid_ctrl import ilid_pkg::*; #(
    parameter int CAPACITY = ILID_CAPACITY,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [POS_W-1:0]  in_pos,
    input  logic [VAL_W-1:0]  in_value,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [VAL_W-1:0]  ram_wr_data,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [VAL_W-1:0]  ram_rd_data,
    output logic [CNT_W-1:0]  count
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_PUT   = 6'b000100,
        ST_DRD   = 6'b001000,
        ST_DOUT  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]   src_reg, src_next;
    logic [ADDR_W-1:0]  dst_reg, dst_next;
    logic               pend_reg, pend_next;
    logic               ok_reg, ok_next;

    logic [CNT_W-1:0]   step_out;
    logic               more;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic               insert_mode;

    // The shared unit: one step of the cell pointer, down for insert and up otherwise,
    // plus the compare that decides whether another cell has to move.
    assign insert_mode = (cmd_reg == CMD_INSERT);
    assign step_out    = insert_mode ? (src_reg - CNT_W'(1)) : (src_reg + CNT_W'(1));
    assign more        = insert_mode ? (src_reg > pos_reg) : (step_out < count_reg);

    assign pos_ext = CMP_W'(in_pos);
    assign cnt_ext = CMP_W'(count_reg);
    assign count   = count_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        ok_next     = ok_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = dst_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = (state_reg == ST_SHIFT) ? step_out[ADDR_W-1:0] : src_reg[ADDR_W-1:0];

        res.ok          = ok_reg;
        res.list_length = LEN_W'(count_reg);
        res.has_item    = 1'b0;
        res.item_value  = '0;
        res.last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next  = cmd_t'(in_cmd);
                    pos_next  = CNT_W'(in_pos);
                    val_next  = in_value;
                    pend_next = 1'b0;
                    case (cmd_t'(in_cmd))
                        CMD_INSERT: begin
                            if (pos_ext > cnt_ext || count_reg == CNT_W'(CAPACITY)) begin
                                ok_next    = 1'b0;
                                state_next = ST_RESP;
                            end else begin
                                src_next   = count_reg;
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                ok_next    = 1'b0;
                                state_next = ST_RESP;
                            end else begin
                                src_next   = CNT_W'(in_pos);
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_DUMP: begin
                            src_next = '0;
                            ok_next  = 1'b1;
                            if (count_reg == '0) begin
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_DRD;
                            end
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                // A read issued last cycle lands now and is written one place over.
                if (pend_reg) begin
                    ram_wr_en = 1'b1;
                end
                if (more) begin
                    pend_next = 1'b1;
                    dst_next  = src_reg[ADDR_W-1:0];
                    src_next  = step_out;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                ok_next = 1'b1;
                if (insert_mode) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pos_reg[ADDR_W-1:0];
                    ram_wr_data = val_reg;
                    count_next  = count_reg + CNT_W'(1);
                end else begin
                    count_next  = count_reg - CNT_W'(1);
                end
                state_next = ST_RESP;
            end
            ST_DRD: begin
                state_next = ST_DOUT;
            end
            ST_DOUT: begin
                res_valid      = 1'b1;
                res.ok         = 1'b1;
                res.has_item   = 1'b1;
                res.item_value = ram_rd_data;
                res.last       = (step_out == count_reg);
                if (res_ready) begin
                    if (step_out == count_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        src_next   = step_out;
                        state_next = ST_DRD;
                    end
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        ok_reg  <= ok_next;
    end

endmodule

FILE: design/indexed_list_insert_delete_top.sv
// Positional list of up to CAPACITY signed 32-bit values driven by command beats:
// insert, delete or dump. Insert and delete answer with one beat carrying ok and the
// new length; dump sends every entry in order with tlast on the final one, or a single
// beat with tuser low for an empty list. The entries live in one single-port-write RAM
// and a sequencer moves them one cell per cycle with a shared step-and-compare unit,
// so an insert or delete first moves M entries (length - position for an insert, one
// fewer for a delete) and then presents its beat, a rejected or unused command goes
// straight to its response beat, and a dump reads each entry and then presents it.
// A command beat is taken only while the sequencer is idle, which it is again in the
// cycle after its last result enters the output register.
module indexed_list_insert_delete_top import ilid_pkg::*; #(
    parameter int CAPACITY = ILID_CAPACITY,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int ADDR_W = $clog2(CAPACITY)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], position[6:2], value[38:7], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ok[0], list_length[5:1], item_value[37:6], zero fill
    output logic [0:0]  m_tuser,   // has_item[0]
    output logic        m_tlast
);

    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [VAL_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [VAL_W-1:0]  ram_rd_data;
    logic [CNT_W-1:0]  count;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg, m_res_next;

    ilid_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tdata[1:0]),
        .in_pos     (s_tdata[6:2]),
        .in_value   (s_tdata[38:7]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_wr_en  (ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .ram_rd_addr(ram_rd_addr),
        .ram_rd_data(ram_rd_data),
        .count      (count)
    );

    ilid_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.item_value, m_res_reg.list_length, m_res_reg.ok};
    assign m_tuser  = m_res_reg.has_item;
    assign m_tlast  = m_res_reg.last;

    // A dumped entry always reports success.
    a_item_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata[0])
        else $error("dumped entry without ok");

    // Only a dump gives more than one beat, so a beat without an entry closes its command.
    a_plain_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[37:6] == 32'd0))
        else $error("status beat not final or carries a value");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(count) <= CAPACITY))
        else $error("list length beyond capacity");

    // The sequencer is busy in the cycle after it takes a command, so it takes no other then.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while busy");

endmodule
